FILE: hw/rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, character codes and helpers for the format specifier parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Accumulator precision; reported values are limited to 16 bits.
  localparam int NUMBER_BITS = 16;
  localparam int FIELD_W     = 16;
  localparam int ACC_W       = (NUMBER_BITS > FIELD_W) ? FIELD_W : NUMBER_BITS;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_J     = 8'h6a;

  // Flag bit positions
  localparam int FLAG_ALT   = 0;
  localparam int FLAG_SPACE = 1;
  localparam int FLAG_ZERO  = 2;
  localparam int FLAG_PLUS  = 3;
  localparam int FLAG_MINUS = 4;

  typedef enum logic [2:0] {
    SIZE_NONE = 3'd0,
    SIZE_HH   = 3'd1,
    SIZE_H    = 3'd2,
    SIZE_LL   = 3'd3,
    SIZE_L    = 3'd4,
    SIZE_Z    = 3'd5,
    SIZE_J    = 3'd6
  } size_code_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_H    = 2'd1,
    PEND_L    = 2'd2
  } pend_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_WIDTH = 2'd1,
    MODE_PREC  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    logic         alt_flag;
    logic         space_sign;
    logic         zero_pad;
    logic         plus_sign;
    logic         left_justify;
    logic [15:0]  field_width;
    logic [15:0]  prec_value;
    logic         prec_seen;
    logic [2:0]   size_code;
    logic [7:0]   conversion;
    logic         ended_by_nul;
  } out_item_t;

  typedef struct packed {
    logic [4:0]       flag_bits;
    logic [ACC_W-1:0] width_acc;
    logic [ACC_W-1:0] prec_acc;
    logic             prec_flag;
    size_code_t       size_sel;
    pend_t            pending_letter;
    mode_t            digit_mode;
  } spec_state_t;

  // Conversion letters: s d i c % u n o e E x X p G g S D C O U
  function automatic logic is_conversion(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      8'h73, 8'h64, 8'h69, 8'h63, 8'h25, 8'h75, 8'h6e, 8'h6f, 8'h65, 8'h45,
      8'h78, 8'h58, 8'h70, 8'h47, 8'h67, 8'h53, 8'h44, 8'h43, 8'h4f, 8'h55:
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // acc * 10 + digit, saturating at all ones
  function automatic logic [ACC_W-1:0] acc_push(logic [ACC_W-1:0] acc, logic [3:0] d);
    logic [ACC_W+3:0] wide;
    logic [ACC_W+3:0] v;
    wide = {4'b0000, acc};
    v = (wide << 3) + (wide << 1) + {{ACC_W{1'b0}}, d};
    return (v[ACC_W+3:ACC_W] != 4'b0000) ? {ACC_W{1'b1}} : v[ACC_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/format_spec_parser_top.sv
// ----------------------------------------------------------------------------
// format_spec_parser_top
// Printf conversion specification parser, one format byte per beat.
// ----------------------------------------------------------------------------
// Pipeline: each input beat is held in the input register, then decoded
//   into the result register.
// Throughput: one byte per cycle; the decode stage stalls only while a
//   finished record waits in the result register.
// Reset: rst clears both stage valids and the record state.
module format_spec_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fsp_pkg::out_item_t out_data
);

  fsp_pkg::in_item_t    in_q;
  logic                 in_q_valid;
  fsp_pkg::spec_state_t spec_st;
  fsp_pkg::spec_state_t spec_st_next;
  fsp_pkg::out_item_t   res;
  fsp_pkg::out_item_t   out_q;
  logic                 out_q_valid;
  logic                 emit;
  logic                 advance;

  fsp_decode u_decode (
    .st      (spec_st),
    .item    (in_q),
    .st_next (spec_st_next),
    .res     (res),
    .emit    (emit)
  );

  // Decode proceeds when the result slot is free or being drained
  assign advance   = in_q_valid && (!out_q_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign out_valid = out_q_valid;
  assign out_data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid  <= 1'b0;
      out_q_valid <= 1'b0;
      spec_st     <= '0;
    end else begin
      if (in_ready) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        spec_st     <= spec_st_next;
        out_q_valid <= emit;
      end else if (out_ready) begin
        out_q_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

endmodule

FILE: hw/rtl/fsp_decode.sv
// ----------------------------------------------------------------------------
// fsp_decode
// Per-byte decode: next record state and the emitted record, if any.
// ----------------------------------------------------------------------------
module fsp_decode (
  input  fsp_pkg::spec_state_t st,
  input  fsp_pkg::in_item_t    item,
  output fsp_pkg::spec_state_t st_next,
  output fsp_pkg::out_item_t   res,
  output logic                 emit
);

  fsp_pkg::spec_state_t base;
  logic                 is_digit;
  logic [3:0]           digit;

  always_comb begin
    base     = item.start_req ? '0 : st;
    is_digit = (item.ch >= fsp_pkg::CH_ZERO) && (item.ch <= fsp_pkg::CH_NINE);
    digit    = 4'(item.ch - fsp_pkg::CH_ZERO);
    emit     = (item.ch == fsp_pkg::CH_NUL) || fsp_pkg::is_conversion(item.ch);

    res.alt_flag     = base.flag_bits[fsp_pkg::FLAG_ALT];
    res.space_sign   = base.flag_bits[fsp_pkg::FLAG_SPACE];
    res.zero_pad     = base.flag_bits[fsp_pkg::FLAG_ZERO];
    res.plus_sign    = base.flag_bits[fsp_pkg::FLAG_PLUS];
    res.left_justify = base.flag_bits[fsp_pkg::FLAG_MINUS];
    res.field_width  = fsp_pkg::FIELD_W'(base.width_acc);
    res.prec_value   = fsp_pkg::FIELD_W'(base.prec_acc);
    res.prec_seen    = base.prec_flag;
    res.size_code    = base.size_sel;
    res.conversion   = item.ch;
    res.ended_by_nul = (item.ch == fsp_pkg::CH_NUL);

    st_next = base;
    if (emit) begin
      st_next = '0;
    end else begin
      st_next.pending_letter = fsp_pkg::PEND_NONE;
      // '0' is a digit only inside a run
      if (is_digit && (item.ch != fsp_pkg::CH_ZERO ||
                       base.digit_mode != fsp_pkg::MODE_NONE)) begin
        unique case (base.digit_mode)
          fsp_pkg::MODE_PREC:  st_next.prec_acc  = fsp_pkg::acc_push(base.prec_acc, digit);
          fsp_pkg::MODE_WIDTH: st_next.width_acc = fsp_pkg::acc_push(base.width_acc, digit);
          default: begin
            st_next.width_acc  = fsp_pkg::acc_push('0, digit);
            st_next.digit_mode = fsp_pkg::MODE_WIDTH;
          end
        endcase
      end else begin
        st_next.digit_mode = fsp_pkg::MODE_NONE;
        unique case (item.ch)
          fsp_pkg::CH_HASH:  st_next.flag_bits[fsp_pkg::FLAG_ALT]   = 1'b1;
          fsp_pkg::CH_SPACE: st_next.flag_bits[fsp_pkg::FLAG_SPACE] = 1'b1;
          fsp_pkg::CH_ZERO:  st_next.flag_bits[fsp_pkg::FLAG_ZERO]  = 1'b1;
          fsp_pkg::CH_PLUS:  st_next.flag_bits[fsp_pkg::FLAG_PLUS]  = 1'b1;
          fsp_pkg::CH_MINUS: st_next.flag_bits[fsp_pkg::FLAG_MINUS] = 1'b1;
          fsp_pkg::CH_DOT: begin
            st_next.prec_flag  = 1'b1;
            st_next.prec_acc   = '0;
            st_next.digit_mode = fsp_pkg::MODE_PREC;
          end
          fsp_pkg::CH_H: begin
            if (base.pending_letter == fsp_pkg::PEND_H) begin
              st_next.size_sel = fsp_pkg::SIZE_HH;
            end else begin
              st_next.size_sel       = fsp_pkg::SIZE_H;
              st_next.pending_letter = fsp_pkg::PEND_H;
            end
          end
          fsp_pkg::CH_L: begin
            if (base.pending_letter == fsp_pkg::PEND_L) begin
              st_next.size_sel = fsp_pkg::SIZE_LL;
            end else begin
              st_next.size_sel       = fsp_pkg::SIZE_L;
              st_next.pending_letter = fsp_pkg::PEND_L;
            end
          end
          fsp_pkg::CH_Z: st_next.size_sel = fsp_pkg::SIZE_Z;
          fsp_pkg::CH_J: st_next.size_sel = fsp_pkg::SIZE_J;
          default: ;
        endcase
      end
    end
  end

endmodule
